@@ design/fmacl_pkg.sv @@
// Shared types and constants for the first-match address filter.
`default_nettype none
package fmacl_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_CHECK  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_REPLY
   } state_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [63:0] net_hi;
      logic [63:0] net_lo;
      logic [63:0] mask_hi;
      logic [63:0] mask_lo;
      logic        permit;
   } rule_entry_type;

   typedef struct packed {
      logic latch;
      logic clear;
      logic insert;
      logic walk_start;
      logic walk_run;
      logic verdict_en;
      logic verdict_allowed;
      logic verdict_status;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    exists;
      logic    numeric;
      logic    count_zero;
      logic    full;
      logic    hit;
      logic    hit_permit;
      logic    miss_end;
      logic    rsp_free;
   } dp_sts_type;

endpackage
`default_nettype wire

@@ design/fmacl_ctrl.sv @@
// Controller state machine for the first-match address filter.
`default_nettype none
module fmacl_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  fmacl_pkg::dp_sts_type  sts,
   output fmacl_pkg::ctrl_cmd_type cmd
);
   import fmacl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in       = ST_REPLY;
            cmd.verdict_en = 1'b1;
            case (sts.cmd)
               CMD_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               CMD_INSERT: begin
                  cmd.insert         = 1'b1;
                  cmd.verdict_status = sts.full ? STATUS_FULL : STATUS_OK;
               end
               CMD_CHECK: begin
                  if (!sts.exists) begin
                     cmd.verdict_allowed = 1'b1;
                  end else if (sts.numeric && !sts.count_zero) begin
                     cmd.verdict_en = 1'b0;
                     cmd.walk_start = 1'b1;
                     state_in       = ST_WALK;
                  end
               end
               default: begin
                  cmd.verdict_allowed = 1'b0;
               end
            endcase
         end
         ST_WALK: begin
            cmd.walk_run = 1'b1;
            if (sts.hit) begin
               cmd.verdict_en      = 1'b1;
               cmd.verdict_allowed = sts.hit_permit;
               state_in            = ST_REPLY;
            end else if (sts.miss_end) begin
               cmd.verdict_en = 1'b1;
               state_in       = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ design/fmacl_dp.sv @@
// Datapath for the first-match address filter: item registers, rule table, walk, response.
`default_nettype none
module fmacl_dp #(
   parameter int RULES = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [1:0]              req_cmd,
   input  wire  [63:0]             req_addr_hi,
   input  wire  [63:0]             req_addr_lo,
   input  wire  [63:0]             req_mask_hi,
   input  wire  [63:0]             req_mask_lo,
   input  wire                     req_permit,
   input  wire                     req_addr_numeric,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic                    rsp_allowed,
   output logic                    rsp_status,
   input  fmacl_pkg::ctrl_cmd_type cmd,
   output fmacl_pkg::dp_sts_type   sts
);
   import fmacl_pkg::*;

   localparam int CW = $clog2(RULES + 1);
   localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;

   logic [1:0]     cmd_ff;
   logic [63:0]    addr_hi_ff;
   logic [63:0]    addr_lo_ff;
   logic [63:0]    mask_hi_ff;
   logic [63:0]    mask_lo_ff;
   logic           permit_ff;
   logic           numeric_ff;

   rule_entry_type rule_mem [RULES];
   rule_entry_type rd_ff;

   logic [CW-1:0]  count_ff, count_in;
   logic           exists_ff, exists_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic           pend_ff, pend_in;
   logic           last_ff, last_in;
   logic           allowed_ff;
   logic           status_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_allowed_ff;
   logic           rsp_status_ff;

   logic           full;
   logic           fetch;
   logic           hit;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff     <= req_cmd;
         addr_hi_ff <= req_addr_hi;
         addr_lo_ff <= req_addr_lo;
         mask_hi_ff <= req_mask_hi;
         mask_lo_ff <= req_mask_lo;
         permit_ff  <= req_permit;
         numeric_ff <= req_addr_numeric;
      end
   end

   assign full  = (count_ff == CW'(RULES));
   assign fetch = cmd.walk_run && (ptr_ff != count_ff);

   always_ff @(posedge clock) begin
      if (cmd.insert && !full) begin
         rule_mem[count_ff[IW-1:0]] <= '{net_hi:  addr_hi_ff,
                                         net_lo:  addr_lo_ff,
                                         mask_hi: mask_hi_ff,
                                         mask_lo: mask_lo_ff,
                                         permit:  permit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         rd_ff <= rule_mem[ptr_ff[IW-1:0]];
      end
   end

   assign hit = pend_ff
                && ((addr_hi_ff & rd_ff.mask_hi) == rd_ff.net_hi)
                && ((addr_lo_ff & rd_ff.mask_lo) == rd_ff.net_lo);

   always_comb begin
      count_in     = count_ff;
      exists_in    = exists_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.clear) begin
         count_in  = '0;
         exists_in = 1'b0;
      end
      if (cmd.insert) begin
         exists_in = 1'b1;
         if (!full) begin
            count_in = CW'(count_ff + CW'(1));
         end
      end
      if (cmd.walk_start) begin
         ptr_in = '0;
      end else if (fetch) begin
         ptr_in  = CW'(ptr_ff + CW'(1));
         pend_in = 1'b1;
         last_in = (CW'(ptr_ff + CW'(1)) == count_ff);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         exists_ff    <= 1'b0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         exists_ff    <= exists_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.verdict_en) begin
         allowed_ff <= cmd.verdict_allowed;
         status_ff  <= cmd.verdict_status;
      end
      if (cmd.rsp_load) begin
         rsp_allowed_ff <= allowed_ff;
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;
   assign rsp_status  = rsp_status_ff;

   always_comb begin
      sts            = '0;
      sts.cmd        = cmd_type'(cmd_ff);
      sts.exists     = exists_ff;
      sts.numeric    = numeric_ff;
      sts.count_zero = (count_ff == '0);
      sts.full       = full;
      sts.hit        = hit;
      sts.hit_permit = rd_ff.permit;
      sts.miss_end   = pend_ff && !hit && last_ff;
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RULES))
      else $error("rule count beyond table depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response loaded over a stalled response");

   a_clear_drops: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (!exists_ff && count_ff == '0))
      else $error("clear left a table behind");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && !full) |=> (count_ff == CW'($past(count_ff) + CW'(1))))
      else $error("insert did not advance rule count");
`endif

endmodule
`default_nettype wire

@@ design/first_match_ip_acl.sv @@
// Top level of the first-match masked address filter.
// Usage:
//   req_* carries one command per transaction: clear the table, insert a rule
//   (network, mask, permit) at the end, or check an address. rsp_* returns
//   exactly one transaction per command with allowed and status.
//   A check walks stored rules in insertion order through the rule table
//   memory, one rule read per cycle; the first rule whose masked address
//   equals its network decides. No match or a non-numeric address denies;
//   no table allows all.
// Sequence:
//   clear, insert, unknown command and a check that needs no walk pass through
//   the states EXEC and REPLY; a check that walks passes through EXEC, WALK and
//   REPLY, and stays in WALK until the deciding rule is compared, or until the
//   last stored rule when no rule matches.
//   One command is in work at a time; the next is accepted once its response
//   sits in the output register.
// Reset: synchronous; empties the table and marks it as absent.
// Stall: rsp_stall holds the response; a new request is accepted meanwhile,
//   but its own response waits until the output register frees up.
`default_nettype none
module first_match_ip_acl #(
   parameter int RULES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_cmd,
   input  wire  [63:0] req_addr_hi,
   input  wire  [63:0] req_addr_lo,
   input  wire  [63:0] req_mask_hi,
   input  wire  [63:0] req_mask_lo,
   input  wire         req_permit,
   input  wire         req_addr_numeric,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_allowed,
   output logic        rsp_status
);
   import fmacl_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   fmacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fmacl_dp #(
      .RULES (RULES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_addr_hi      (req_addr_hi),
      .req_addr_lo      (req_addr_lo),
      .req_mask_hi      (req_mask_hi),
      .req_mask_lo      (req_mask_lo),
      .req_permit       (req_permit),
      .req_addr_numeric (req_addr_numeric),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_allowed      (rsp_allowed),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
`default_nettype wire
